// ----- src/keyed_count_table_macros.svh -----
// Assertion macros for the keyed count table.
// Uses the clk and rst_n names of the module that includes it.
`ifndef KEYED_COUNT_TABLE_MACROS_SVH
`define KEYED_COUNT_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define KCT_ASSERT_IMP(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/kct_pkg.sv -----
// Types and constants shared by the keyed count table.
// No dependencies.
package kct_pkg;

    localparam int NAME_BYTES = 10;
    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int COUNT_W    = 31;
    localparam int STATUS_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [63:0]        key_low;
        logic [15:0]        key_high;
        logic [COUNT_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  taken;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic               cmp;       // latch key match
        logic               upd;       // apply update
        logic               create;    // first free cell claims the key
        logic               clear;     // matching cell is freed
        logic [COUNT_W-1:0] new_count;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NORM,
        S_CMP,
        S_UPD
    } kct_state_t;

endpackage

// ----- src/kct_req_if.sv -----
// Request channel: valid, ready and one request item.
// Depends on kct_pkg.
interface kct_req_if;
    import kct_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/kct_rsp_if.sv -----
// Response channel: valid, ready and one result item.
// Depends on kct_pkg.
interface kct_rsp_if;
    import kct_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/kct_norm.sv -----
// Key normalizer: clears every byte from the first zero byte on,
// and drops bytes beyond KEY_BYTES. Depends on kct_pkg.
module kct_norm #(
    parameter int KEY_BYTES = 10
) (
    input  logic [kct_pkg::NAME_W-1:0]  raw,
    output logic [KEY_BYTES*8-1:0]      key
);
    import kct_pkg::*;

    logic [NAME_W-1:0] full;

    always_comb
    begin
        logic alive;
        alive = 1'b1;
        full  = '0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (i >= KEY_BYTES || raw[8*i +: 8] == 8'h00)
                alive = 1'b0;
            if (alive)
                full[8*i +: 8] = raw[8*i +: 8];
        end
    end

    assign key = full[KEY_BYTES*8-1:0];
endmodule

// ----- src/kct_cell.sv -----
// One table entry: valid bit, key and count, with its link to the neighbors.
// Depends on kct_pkg.
module kct_cell #(
    parameter int KEY_BYTES = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [KEY_BYTES*8-1:0]       key,
    input  kct_pkg::cell_cmd_t           cmd,
    input  logic                         free_in,
    output logic                         free_out,
    input  logic [kct_pkg::COUNT_W-1:0]  count_in,
    output logic [kct_pkg::COUNT_W-1:0]  count_out,
    output logic                         valid,
    output logic                         hit
);
    import kct_pkg::*;

    logic                  valid_reg;
    logic                  hit_reg;
    logic [KEY_BYTES*8-1:0] key_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  claim;

    // Lowest free cell claims a new key.
    assign claim     = !valid_reg && !free_in;
    assign free_out  = free_in || !valid_reg;
    assign count_out = count_in | (hit_reg ? count_reg : '0);
    assign valid     = valid_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else if (cmd.cmp)
        begin
            hit_reg <= valid_reg && (key_reg == key);
        end
        else if (cmd.upd)
        begin
            if (hit_reg && cmd.clear)
                valid_reg <= 1'b0;
            else if (cmd.create && claim)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            if (hit_reg)
                count_reg <= cmd.new_count;
            else if (cmd.create && claim)
            begin
                key_reg   <= key;
                count_reg <= cmd.new_count;
            end
        end
    end
endmodule

// ----- src/keyed_count_table.sv -----
// Keyed count table: a table of ENTRIES named counters, each keyed by a name of up to
// KEY_BYTES bytes that ends at its first zero byte. An add merges its amount into the
// matching entry (saturating at 2^31-1) or creates an entry in a free cell, else reports
// the table full; a take removes min(amount, count), returns it, and frees the entry when
// its count reaches zero. Every request yields exactly one result. A request passes through
// the transfer, key normalization, a key compare done in all cells at once, and the update,
// which waits only while the output register holds a result not yet taken.
// The next request is accepted right after the update, even while that result waits.
// Free cells are claimed lowest first through a free link that runs along the cell row,
// and the matching count runs back to the controller along the same row. All entries are
// free right after reset; there is no clearing pass.
// Depends on kct_pkg, kct_req_if, kct_rsp_if, kct_norm, kct_cell and the macro header.
`include "keyed_count_table_macros.svh"

module keyed_count_table #(
    parameter int ENTRIES   = 64,
    parameter int KEY_BYTES = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    kct_req_if.sink    req,
    kct_rsp_if.source  rsp
);
    import kct_pkg::*;

    localparam int KEY_W = KEY_BYTES * 8;

    kct_state_t state_reg, state_next;

    // Request held for the whole operation.
    logic               mode_reg;
    logic [COUNT_W-1:0] amount_reg;
    logic [NAME_W-1:0]  raw_reg;
    logic [KEY_W-1:0]   nkey_reg;
    logic [KEY_W-1:0]   nkey_next;

    // Output register.
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_data_reg, rsp_data_next;

    cell_cmd_t cmd;
    logic      upd_fire;
    logic      hit_any;
    logic      free_any;

    logic [ENTRIES:0]   free_c;
    logic [COUNT_W-1:0] cnt_c [ENTRIES+1];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] hit_vec;

    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] take_q;

    // ---------------- key normalization ----------------
    kct_norm #(
        .KEY_BYTES(KEY_BYTES)
    ) u_norm (
        .raw(raw_reg),
        .key(nkey_next)
    );

    // ---------------- cell row ----------------
    assign free_c[0] = 1'b0;
    assign cnt_c[0]  = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        kct_cell #(
            .KEY_BYTES(KEY_BYTES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (nkey_reg),
            .cmd      (cmd),
            .free_in  (free_c[g]),
            .free_out (free_c[g+1]),
            .count_in (cnt_c[g]),
            .count_out(cnt_c[g+1]),
            .valid    (valid_vec[g]),
            .hit      (hit_vec[g])
        );
    end

    assign hit_any   = |hit_vec;
    assign free_any  = free_c[ENTRIES];
    assign hit_count = cnt_c[ENTRIES];

    // ---------------- update arithmetic ----------------
    assign sum    = {1'b0, hit_count} + {1'b0, amount_reg};
    assign take_q = (amount_reg < hit_count) ? amount_reg : hit_count;

    // Advance the update only when the output register can take the result.
    assign upd_fire = (state_reg == S_UPD) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        cmd           = '0;
        cmd.cmp       = (state_reg == S_CMP);
        cmd.upd       = upd_fire;
        rsp_data_next = '0;
        if (mode_reg == MODE_ADD)
        begin
            if (hit_any)
            begin
                cmd.new_count        = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
                rsp_data_next.status = ST_MERGED;
            end
            else if (free_any)
            begin
                cmd.create           = 1'b1;
                cmd.new_count        = amount_reg;
                rsp_data_next.status = ST_CREATED;
            end
            else
            begin
                rsp_data_next.status = ST_FULL;
            end
        end
        else
        begin
            if (hit_any)
            begin
                cmd.new_count        = hit_count - take_q;
                cmd.clear            = (hit_count == take_q);
                rsp_data_next.taken  = take_q;
                rsp_data_next.status = ST_TAKEN;
            end
            else
            begin
                rsp_data_next.status = ST_ABSENT;
            end
        end
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req.valid) state_next = S_NORM;
            S_NORM: state_next = S_CMP;
            S_CMP:  state_next = S_UPD;
            S_UPD:  if (upd_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
            rsp_valid_next = 1'b0;
        if (upd_fire)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the request fields; latch the normalized key in the following cycle.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg   <= req.payload.mode;
            amount_reg <= req.payload.amount;
            raw_reg    <= {req.payload.key_high, req.payload.key_low};
        end
        if (state_reg == S_NORM)
            nkey_reg <= nkey_next;
        if (upd_fire)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // ---------------- checks ----------------
    `KCT_ASSERT(a_hit_unique, $onehot0(hit_vec), "more than one cell matches the key")
    `KCT_ASSERT_IMP(a_taken_bound, upd_fire, rsp_data_next.taken <= amount_reg,
        "taken exceeds requested amount")
    `KCT_ASSERT_IMP(a_create_no_hit, upd_fire && cmd.create, !hit_any && free_any,
        "entry created although key present or table full")
    `KCT_ASSERT(a_create_grows, (upd_fire && cmd.create) |=>
        ($countones(valid_vec) == $past($countones(valid_vec)) + 1),
        "create did not claim exactly one cell")
endmodule
